[hdl/setgl_pkg.sv]
// ----------------------------------------------------------------------------
// setgl_pkg
// Types and constants shared by the silhouette edge toggle table modules.
// ----------------------------------------------------------------------------
package setgl_pkg;

    localparam int VTX_W     = 16;
    localparam int RIDX_W    = 8;
    localparam int CNT_OUT_W = 9;
    localparam int SLOT_W    = 8;
    localparam int ENTRY_W   = 2 * VTX_W;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [M_TUSER_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_READ     = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN,
        DP_HIT,
        DP_APPEND,
        DP_DROP,
        DP_LAST_WR,
        DP_RD_ISSUE,
        DP_RD_DONE,
        DP_CLEAR,
        DP_PUSH
    } t_dp_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_LAST_WR,
        S_RD_DONE,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_opcode op;
        logic    hit;
        logic    scan_end;
        logic    full;
        logic    out_free;
    } t_sts;

endpackage

[hdl/setgl_ctrl.sv]
// ----------------------------------------------------------------------------
// setgl_ctrl
// Sequencer: steps the datapath through add, read and clear operations.
// ----------------------------------------------------------------------------
module setgl_ctrl
    import setgl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_tvalid,
    output logic   o_s_tready,
    input  t_sts   i_sts,
    output t_dp_op o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_ADD:   n_state = S_SCAN;
                    OP_READ:  n_state = S_RD_DONE;
                    OP_CLEAR: n_state = S_PUSH;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_LAST_WR;
                end else if (i_sts.scan_end) begin
                    n_state = S_PUSH;
                end
            end
            S_LAST_WR: n_state = S_PUSH;
            S_RD_DONE: n_state = S_PUSH;
            S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd = DP_LOAD;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_READ:  o_cmd = DP_RD_ISSUE;
                    OP_CLEAR: o_cmd = DP_CLEAR;
                    default:  o_cmd = DP_NOP;
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd = DP_HIT;
                end else if (i_sts.scan_end) begin
                    o_cmd = i_sts.full ? DP_DROP : DP_APPEND;
                end else begin
                    o_cmd = DP_SCAN;
                end
            end
            S_LAST_WR: o_cmd = DP_LAST_WR;
            S_RD_DONE: o_cmd = DP_RD_DONE;
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd = DP_PUSH;
                end
            end
            default: o_cmd = DP_NOP;
        endcase
    end

endmodule

[hdl/setgl_dp.sv]
// ----------------------------------------------------------------------------
// setgl_dp
// Datapath: edge memory, held count, scan pipeline, result and output regs.
// ----------------------------------------------------------------------------
module setgl_dp
    import setgl_pkg::*;
#(
    parameter int MAX_EDGES = 256
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_op               i_cmd,
    output t_sts                 o_sts,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    logic [ENTRY_W-1:0]   r_mem [MAX_EDGES];
    logic [ENTRY_W-1:0]   r_rdata;

    t_opcode              r_op;
    logic [VTX_W-1:0]     r_va;
    logic [VTX_W-1:0]     r_vb;
    logic [RIDX_W-1:0]    r_ri;

    logic [CW-1:0]        r_idx;
    logic                 r_cmp_vld;
    logic [AW-1:0]        r_cmp_idx;
    logic [AW-1:0]        r_hit_idx;
    logic [CW-1:0]        r_count;

    t_status              r_res_status;
    logic [CNT_OUT_W-1:0] r_res_count;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [VTX_W-1:0]     r_res_a;
    logic [VTX_W-1:0]     r_res_b;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [VTX_W-1:0]     r_out_a;
    logic [VTX_W-1:0]     r_out_b;

    logic                 w_issue;
    logic                 w_match;
    logic                 w_full;
    logic                 w_out_free;
    logic                 w_rd_ok;
    logic [CW-1:0]        w_last;
    logic [CW-1:0]        w_inc;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic [ENTRY_W-1:0]   w_wr_data;
    logic                 w_we;

    assign w_issue    = (r_idx < r_count);
    assign w_match    = ((r_rdata[VTX_W-1:0] == r_va) && (r_rdata[ENTRY_W-1:VTX_W] == r_vb))
                     || ((r_rdata[VTX_W-1:0] == r_vb) && (r_rdata[ENTRY_W-1:VTX_W] == r_va));
    assign w_full     = (r_count == CW'(MAX_EDGES));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_rd_ok    = (32'(r_ri) < 32'(r_count));
    assign w_last     = r_count - CW'(1);
    assign w_inc      = r_count + CW'(1);

    assign o_sts.op       = r_op;
    assign o_sts.hit      = r_cmp_vld && w_match;
    assign o_sts.scan_end = !r_cmp_vld && !w_issue;
    assign o_sts.full     = w_full;
    assign o_sts.out_free = w_out_free;

    always_comb begin
        unique case (i_cmd)
            DP_HIT:      w_rd_addr = w_last[AW-1:0];
            DP_RD_ISSUE: w_rd_addr = AW'(r_ri);
            default:     w_rd_addr = r_idx[AW-1:0];
        endcase
    end

    assign w_we      = (i_cmd == DP_APPEND) || (i_cmd == DP_LAST_WR);
    assign w_wr_addr = (i_cmd == DP_APPEND) ? r_count[AW-1:0] : r_hit_idx;
    assign w_wr_data = (i_cmd == DP_APPEND) ? {r_vb, r_va} : r_rdata;

    // edge memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd)
                DP_LOAD: begin
                    r_idx     <= '0;
                    r_cmp_vld <= 1'b0;
                end
                DP_SCAN: begin
                    r_cmp_vld <= w_issue;
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                DP_APPEND:  r_count <= w_inc;
                DP_LAST_WR: r_count <= w_last;
                DP_CLEAR:   r_count <= '0;
                default: ;
            endcase
            if (i_cmd == DP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_op <= t_opcode'(i_s_tuser);
                r_va <= i_s_tdata[VTX_W-1:0];
                r_vb <= i_s_tdata[2*VTX_W-1:VTX_W];
                r_ri <= i_s_tdata[2*VTX_W+RIDX_W-1:2*VTX_W];
            end
            DP_SCAN: begin
                r_cmp_idx <= r_idx[AW-1:0];
            end
            DP_HIT: begin
                r_hit_idx <= r_cmp_idx;
            end
            DP_APPEND: begin
                r_res_status <= ST_APPENDED;
                r_res_count  <= CNT_OUT_W'(w_inc);
                r_res_slot   <= SLOT_W'(r_count);
                r_res_a      <= '0;
                r_res_b      <= '0;
            end
            DP_DROP: begin
                r_res_status <= ST_DROPPED;
                r_res_count  <= CNT_OUT_W'(r_count);
                r_res_slot   <= '0;
                r_res_a      <= '0;
                r_res_b      <= '0;
            end
            DP_LAST_WR: begin
                r_res_status <= ST_REMOVED;
                r_res_count  <= CNT_OUT_W'(w_last);
                r_res_slot   <= SLOT_W'(r_hit_idx);
                r_res_a      <= '0;
                r_res_b      <= '0;
            end
            DP_RD_DONE: begin
                r_res_status <= ST_READ;
                r_res_count  <= CNT_OUT_W'(r_count);
                r_res_slot   <= r_ri;
                r_res_a      <= w_rd_ok ? r_rdata[VTX_W-1:0] : '0;
                r_res_b      <= w_rd_ok ? r_rdata[ENTRY_W-1:VTX_W] : '0;
            end
            DP_CLEAR: begin
                r_res_status <= ST_CLEARED;
                r_res_count  <= '0;
                r_res_slot   <= '0;
                r_res_a      <= '0;
                r_res_b      <= '0;
            end
            DP_PUSH: begin
                r_out_status <= r_res_status;
                r_out_count  <= r_res_count;
                r_out_slot   <= r_res_slot;
                r_out_a      <= r_res_a;
                r_out_b      <= r_res_b;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(M_TDATA_W - CNT_OUT_W - SLOT_W - 2*VTX_W)'(0),
                         r_out_b, r_out_a, r_out_slot, r_out_count};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_EDGES)
        else $error("held count above table depth");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_PUSH) |-> w_out_free)
        else $error("result pushed over an untaken output");

    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_HIT) |-> (r_count != '0))
        else $error("match reported on an empty table");

    a_append_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_APPEND) |=> (r_count == $past(w_inc)))
        else $error("append did not grow the count");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_APPEND) |-> !w_full)
        else $error("append into a full table");

endmodule

[hdl/silhouette_edge_toggle_table.sv]
// ----------------------------------------------------------------------------
// silhouette_edge_toggle_table
// Edge list that cancels shared edges: add toggles an edge in or out (dropped
// when full), read returns one slot, clear empties the list.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit first)                         tuser
// s_axis    in   vertex_a[15:0] vertex_b[31:16] read_index[39:32] opcode[1:0]
// m_axis    out  edge_count[8:0] slot[16:9] entry_a[32:17]       status[2:0]
//                entry_b[48:33], zero fill to 56 bits
//
// One operation at a time. An add is bounded by one memory read per held entry
// on the single read port. i_rst_n is synchronous, empties the table and holds
// s_axis_tready low. A stalled result sits in the output register while the next
// transfer is taken; the block then waits at its result step until m_axis_tready.
// ----------------------------------------------------------------------------
module silhouette_edge_toggle_table
    import setgl_pkg::*;
#(
    parameter int MAX_EDGES = 256
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // vertex_a, vertex_b, read_index
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // edge_count, slot, entry_a, entry_b
    output logic [M_TUSER_W-1:0] m_axis_tuser   // status
);

    t_dp_op w_cmd;
    t_sts   w_sts;

    setgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    setgl_dp #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for silhouette_edge_toggle_table. Edge adds, reads,
// clears and unused opcodes go in on s_axis. A shadow copy of the edge table
// predicts every result, and each m_axis transfer is compared field by field.
// Both sides idle at random. Directed tests cover empty, full and
// reverse-orientation cases, and a long random run follows them.
// ----------------------------------------------------------------------------
module testbench;
    import setgl_pkg::*;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct packed {
        t_status               status;
        logic [CNT_OUT_W-1:0]  count;
        logic [SLOT_W-1:0]     slot;
        logic [VTX_W-1:0]      va;
        logic [VTX_W-1:0]      vb;
    } t_edge_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // vertex_a, vertex_b, read_index
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;  // opcode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // edge_count, slot, entry_a, entry_b
    logic [M_TUSER_W-1:0] m_axis_tuser;        // status

    logic [ENTRY_W-1:0] shadow_edges [TABLE_DEPTH];
    int                 shadow_count;
    t_edge_result       pending_results [$];
    t_edge_result       got_res;
    t_edge_result       want_res;
    int                 errors;
    int                 cycles;
    bit                 idle_on;

    silhouette_edge_toggle_table #(
        .MAX_EDGES(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Edge table model; returns 0 when the opcode yields no result.
    function automatic bit toggle_edge(input logic [1:0] op, input logic [15:0] a,
                                       input logic [15:0] b, input logic [7:0] idx,
                                       output t_edge_result r);
        logic [15:0] ea;
        logic [15:0] eb;
        r = '0;
        case (op)
            OP_ADD: begin
                for (int i = 0; i < shadow_count; i++) begin
                    ea = shadow_edges[i][15:0];
                    eb = shadow_edges[i][31:16];
                    if ((ea == a && eb == b) || (ea == b && eb == a)) begin
                        shadow_edges[i] = shadow_edges[shadow_count - 1];
                        shadow_count--;
                        r.status = ST_REMOVED;
                        r.count  = CNT_OUT_W'(shadow_count);
                        r.slot   = SLOT_W'(i);
                        return 1'b1;
                    end
                end
                if (shadow_count >= TABLE_DEPTH) begin
                    r.status = ST_DROPPED;
                    r.count  = CNT_OUT_W'(shadow_count);
                end else begin
                    shadow_edges[shadow_count] = {b, a};
                    r.status = ST_APPENDED;
                    r.slot   = SLOT_W'(shadow_count);
                    shadow_count++;
                    r.count  = CNT_OUT_W'(shadow_count);
                end
                return 1'b1;
            end
            OP_READ: begin
                r.status = ST_READ;
                r.count  = CNT_OUT_W'(shadow_count);
                r.slot   = idx;
                if (idx < shadow_count) begin
                    r.va = shadow_edges[idx][15:0];
                    r.vb = shadow_edges[idx][31:16];
                end
                return 1'b1;
            end
            OP_CLEAR: begin
                shadow_count = 0;
                r.status     = ST_CLEARED;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] a,
                             input logic [15:0] b, input logic [7:0] idx);
        int           gap;
        t_edge_result r;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, b, a};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (toggle_edge(op, a, b, idx, r))
            pending_results.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random stall before each transfer.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.status = t_status'(m_axis_tuser);
            got_res.count  = m_axis_tdata[8:0];
            got_res.slot   = m_axis_tdata[16:9];
            got_res.va     = m_axis_tdata[32:17];
            got_res.vb     = m_axis_tdata[48:33];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tuser %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("status", int'(want_res.status), int'(got_res.status));
                check_field("edge_count", int'(want_res.count), int'(got_res.count));
                check_field("slot", int'(want_res.slot), int'(got_res.slot));
                check_field("entry_a", int'(want_res.va), int'(got_res.va));
                check_field("entry_b", int'(want_res.vb), int'(got_res.vb));
                check_field("zero fill", 0, int'(m_axis_tdata[M_TDATA_W-1:49]));
            end
        end
    end

    task automatic test_directed();
        idle_on = 1'b0;
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd0);
        send_item(OP_READ, 16'hFFFF, 16'hFFFF, 8'd255);
        send_item(OP_ADD, 16'h0000, 16'h0000, 8'd0);     // degenerate edge
        send_item(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(OP_ADD, 16'h1234, 16'hABCD, 8'h00);
        send_item(OP_ADD, 16'h0001, 16'h0002, 8'h00);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd2);
        send_item(OP_ADD, 16'hABCD, 16'h1234, 8'h00);    // reversed, middle slot
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd2);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd3);    // beyond count
        send_item(OP_UNUSED, 16'h5555, 16'hAAAA, 8'h5A);
        send_item(OP_ADD, 16'h0002, 16'h0001, 8'h00);    // removes last entry
        send_item(OP_ADD, 16'h0000, 16'h0000, 8'h00);    // removes slot 0
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd0);
        send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd0);
        send_item(OP_ADD, 16'h8000, 16'h7FFF, 8'hA5);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd0);
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    task automatic test_table_full();
        idle_on = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(OP_ADD, 16'hF000 | 16'(i), 16'(i), 8'($urandom));
        send_item(OP_ADD, 16'h0123, 16'h0456, 8'h00);     // dropped
        send_item(OP_ADD, 16'h0123, 16'h0456, 8'h00);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd255);
        send_item(OP_ADD, 16'd77, 16'hF000 | 16'd77, 8'h00); // reversed match while full
        send_item(OP_ADD, 16'h0123, 16'h0456, 8'h00);     // appended at 255
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd255);
        send_item(OP_READ, 16'h0000, 16'h0000, 8'd77);
        send_item(OP_ADD, 16'h0AAA, 16'h0BBB, 8'h00);     // dropped again
        wait_idle();                                        // hold off until all results in
        send_item(OP_ADD, 16'h0456, 16'h0123, 8'h00);      // removes last slot
        send_item(OP_CLEAR, 16'h0000, 16'h0000, 8'h00);
        wait_idle();
    endtask

    task automatic test_random();
        int          done;
        int          pick;
        int          k;
        logic [1:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  idx;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            op   = pick < 62 ? OP_ADD : pick < 90 ? OP_READ : pick < 92 ? OP_CLEAR
                             : pick < 96 ? OP_UNUSED : OP_ADD;
            a    = 16'($urandom);
            b    = 16'($urandom);
            idx  = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (op == OP_ADD) begin
                if (pick < 35 && shadow_count > 0) begin
                    k = $urandom_range(0, shadow_count - 1);
                    a = shadow_edges[k][15:0];
                    b = shadow_edges[k][31:16];
                    if ($urandom_range(0, 1)) {a, b} = {b, a};
                end else if (pick < 70) begin
                    a = 16'($urandom_range(0, 5));
                    b = 16'($urandom_range(0, 5));
                end
            end else if (op == OP_READ && pick < 70 && shadow_count > 0) begin
                idx = 8'($urandom_range(0, shadow_count - 1));
            end
            send_item(op, a, b, idx);
            if (op != OP_UNUSED) done++;
        end
        wait_idle();
    endtask

    initial begin
        errors       = 0;
        cycles       = 0;
        shadow_count = 0;
        idle_on      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
